// ===== design/pcksum_pkg.sv =====
package pcksum_pkg;

  // Command queue between the front and the back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  // CRC-32, MSB first
  localparam logic [31:0] CrcPoly   = 32'h04C1_1DB7;
  localparam int unsigned ByteShift = 24;

  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [0:0] {
    ST_RUN,
    ST_LEN
  } back_state_e;

  // Feed one byte into the CRC, one polynomial step per bit
  function automatic logic [31:0] crc_feed(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    logic        top;
    c = crc ^ ({24'b0, b} << ByteShift);
    for (int i = 0; i < 8; i++) begin
      top = c[31];
      c   = {c[30:0], 1'b0};
      if (top) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/pcksum_front.sv =====
module pcksum_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [7:0]        data_byte_i,
  output logic              cmd_valid_o,
  output pcksum_pkg::cmd_t  cmd_o,
  input  logic              cmd_pop_i
);
  import pcksum_pkg::*;

  cmd_t             queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             push;
  logic             pop;
  cmd_t             in_cmd;

  // Classify the incoming transaction
  always_comb begin
    in_cmd.finish = req_type_i;
    in_cmd.data   = req_type_i ? 8'h00 : data_byte_i;
  end

  assign in_stall_o  = (count_q == QCntW'(QDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= in_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue count past depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == QCntW'(QDepth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("push lost");

endmodule

// ===== design/pcksum_back.sv =====
module pcksum_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  pcksum_pkg::cmd_t  cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       cksum_value_o,
  output logic [31:0]       byte_total_o,
  output logic              size_overflow_o
);
  import pcksum_pkg::*;

  back_state_e state_q, state_d;
  logic [31:0] crc_q;
  logic [31:0] cnt_q;
  logic        ovf_q;
  logic [31:0] len_q;
  logic        out_valid_q;
  logic [31:0] cksum_q;
  logic [31:0] total_q;
  logic        size_ovf_q;
  logic        out_free;
  logic        emit;
  logic        take_data;
  logic        take_finish;
  logic [32:0] cnt_inc;

  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_inc  = {1'b0, cnt_q} + 33'd1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (cmd_valid_i && cmd_i.finish) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (len_q == '0 && out_free) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    cmd_pop_o   = 1'b0;
    emit        = 1'b0;
    unique case (state_q)
      ST_RUN:  cmd_pop_o = cmd_valid_i;
      ST_LEN:  emit      = (len_q == '0) && out_free;
      default: cmd_pop_o = 1'b0;
    endcase
    take_data   = cmd_pop_o && !cmd_i.finish;
    take_finish = cmd_pop_o && cmd_i.finish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      crc_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take_data) begin
        crc_q <= crc_feed(crc_q, cmd_i.data);
        cnt_q <= cnt_inc[31:0];
        if (cnt_inc[32]) begin
          ovf_q <= 1'b1;
        end
      end else if (take_finish) begin
        len_q <= cnt_q;
      end else if (state_q == ST_LEN && len_q != '0) begin
        // Append the length, low byte first
        crc_q <= crc_feed(crc_q, len_q[7:0]);
        len_q <= {8'h00, len_q[31:8]};
      end else if (emit) begin
        crc_q <= '0;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cksum_q    <= ~crc_q;
      total_q    <= cnt_q;
      size_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cksum_value_o   = cksum_q;
  assign byte_total_o    = total_q;
  assign size_overflow_o = size_ovf_q;

  a_no_pop_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEN) |-> !cmd_pop_o)
    else $error("command taken while appending length");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (crc_q == '0 && cnt_q == '0 && !ovf_q && out_valid_q))
    else $error("state not cleared after report");

  a_len_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEN && len_q != '0) |=> (len_q == {8'h00, $past(len_q[31:8])}))
    else $error("length bytes out of order");

endmodule

// ===== design/posix_cksum_engine_core.sv =====
// POSIX cksum engine: a data transaction (req_type 0) feeds one byte into an
// MSB-first CRC-32 (poly 04C11DB7, init 0) and counts it; a finish transaction
// (req_type 1) appends the byte count low byte first with only the bytes it
// needs, reports the complemented CRC, the 32-bit count and a count overflow
// flag, and clears the state for the next stream. The back end pops a queued data
// byte whenever it is in the run state; a finish loads the length, appends one
// length byte per step, then loads the result register once no report is stalled. A two-entry
// command queue separates the input side from the CRC unit, and the result
// register lets the next stream's bytes enter while a report waits.
module posix_cksum_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] cksum_value_o,
  output logic [31:0] byte_total_o,
  output logic        size_overflow_o
);
  import pcksum_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  pcksum_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pcksum_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cksum_value_o   (cksum_value_o),
    .byte_total_o    (byte_total_o),
    .size_overflow_o (size_overflow_o)
  );

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import pcksum_pkg::*;

  localparam logic [31:0] Crc32Poly = 32'h04C1_1DB7;

  typedef struct packed {
    logic [31:0] cksum;
    logic [31:0] total;
    logic        wrapped;
  } cksum_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        req_type_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] cksum_value_o;
  logic [31:0] byte_total_o;
  logic        size_overflow_o;

  // Running image of the stream being summed
  logic [31:0] stream_crc;
  logic [31:0] stream_len;
  logic        stream_wrapped;

  cksum_report_t pending_reports[$];
  int unsigned   error_count;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;

  posix_cksum_engine_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cksum_value_o  (cksum_value_o),
    .byte_total_o   (byte_total_o),
    .size_overflow_o(size_overflow_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shift a byte in bit by bit, MSB first, folding the feedback per bit
  function automatic logic [31:0] crc32_shift_in(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[31] ^ b[i];
      c  = {c[30:0], 1'b0} ^ (fb ? Crc32Poly : 32'h0);
    end
    return c;
  endfunction

  task automatic track_cmd(input logic fin, input logic [7:0] b);
    cksum_report_t rpt;
    logic [31:0]   crc;
    logic [31:0]   len;
    if (!fin) begin
      stream_crc = crc32_shift_in(stream_crc, b);
      stream_len = stream_len + 32'd1;
      if (stream_len == 32'd0) begin
        stream_wrapped = 1'b1;
      end
    end else begin
      crc = stream_crc;
      len = stream_len;
      // Append only the significant length bytes, low byte first
      while (len != 32'd0) begin
        crc = crc32_shift_in(crc, len[7:0]);
        len = len >> 8;
      end
      rpt.cksum   = ~crc;
      rpt.total   = stream_len;
      rpt.wrapped = stream_wrapped;
      pending_reports.push_back(rpt);
      stream_crc     = 32'd0;
      stream_len     = 32'd0;
      stream_wrapped = 1'b0;
    end
  endtask

  // Called at a rising edge; returns at the edge that accepts the transaction
  task automatic push_cmd(input logic fin, input logic [7:0] b);
    logic taken;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i  <= 1'b0;
      req_type_i  <= 1'($urandom_range(1));
      data_byte_i <= 8'($urandom_range(255));
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= fin;
    data_byte_i <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    track_cmd(fin, b);
  endtask

  task automatic send_stream(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      push_cmd(1'b0, 8'($urandom_range(255)));
    end
    push_cmd(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic test_empty_streams();
    push_cmd(1'b1, 8'h00);
    push_cmd(1'b1, 8'hFF);
    push_cmd(1'b1, 8'hA5);
  endtask

  task automatic test_byte_extremes();
    logic [7:0] pattern[6];
    pattern = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h80, 8'h01};
    push_cmd(1'b0, 8'h00);
    push_cmd(1'b1, 8'hFF);
    push_cmd(1'b0, 8'hFF);
    push_cmd(1'b1, 8'h00);
    foreach (pattern[i]) begin
      push_cmd(1'b0, pattern[i]);
    end
    push_cmd(1'b1, 8'h5A);
  endtask

  // Cover one- and two-byte length tails, including a zero low byte
  task automatic test_length_widths();
    send_stream(255);
    send_stream(256);
  endtask

  task automatic test_random_streams(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        len = 0;
      end else if (pick < 90) begin
        len = $urandom_range(24, 1);
      end else begin
        len = $urandom_range(300, 25);
      end
      send_stream(len);
      sent += len + 1;
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
  end

  // Outputs are stable between the falling edge and the accepting rising edge
  always @(negedge clk_i) begin
    cksum_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: cksum_value %h byte_total %h size_overflow %b",
               cksum_value_o, byte_total_o, size_overflow_o);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (cksum_value_o !== want.cksum) begin
          $error("cksum_value: expected %h, got %h", want.cksum, cksum_value_o);
          error_count++;
        end
        if (byte_total_o !== want.total) begin
          $error("byte_total: expected %h, got %h", want.total, byte_total_o);
          error_count++;
        end
        if (size_overflow_o !== want.wrapped) begin
          $error("size_overflow: expected %b, got %b", want.wrapped, size_overflow_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = 1'b0;
    data_byte_i    = 8'h00;
    stream_crc     = 32'd0;
    stream_len     = 32'd0;
    stream_wrapped = 1'b0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_streams();
    test_byte_extremes();
    test_length_widths();

    test_random_streams(240);
    send_idle_pct = 73;
    test_random_streams(240);
    send_idle_pct  = 0;
    recv_stall_pct = 73;
    test_random_streams(240);
    send_idle_pct  = 33;
    recv_stall_pct = 33;
    test_random_streams(240);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_byte_extremes();

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_reports.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (16) @(posedge clk_i);
    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pcksum_pkg.sv
design/pcksum_front.sv
design/pcksum_back.sv
design/posix_cksum_engine_core.sv
bench/tb_top.sv
